/* rtl/lfsr_ranged_random_defines.svh */
// Assertion macros shared by the lfsr_ranged_random RTL.
`ifndef LFSR_RANGED_RANDOM_DEFINES_SVH
`define LFSR_RANGED_RANDOM_DEFINES_SVH
`ifndef SYNTHESIS
`define LRR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lfsr_ranged_random: assertion failed");
`define LRR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfsr_ranged_random: sequencing assertion failed");
`else
`define LRR_ASSERT(label, prop)
`define LRR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/lrr_pkg.sv */
// Types and constants shared by the ranged LFSR random source.
package lrr_pkg;

   localparam int SEED_W  = 32;
   localparam int RANGE_W = 15;
   localparam int VALUE_W = 10;

   localparam logic [SEED_W-1:0] SEED_RESET  = 32'h3568_3568;
   localparam logic [SEED_W-1:0] SEED_ESCAPE = 32'h0000_30BE;

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // capture the incoming word
      logic step;      // one LFSR shift plus one remainder step
      logic last;      // final step of a draw
      logic load_rsp;  // move the finished result into the output register
   } lrr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_draw;   // incoming word is a draw with a nonzero range
   } lrr_sts_type;

endpackage

/* rtl/lrr_ctrl.sv */
// Controller state machine for the ranged LFSR random source.
`include "lfsr_ranged_random_defines.svh"
module lrr_ctrl
   import lrr_pkg::*;
#(
   parameter int ROUNDS = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  lrr_sts_type sts,
   output lrr_cmd_type cmd
);

   localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_step;

   assign last_step = (cnt_ff == CNT_W'(ROUNDS - 1));
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               state_in   = sts.is_draw ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cmd.last = last_step;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The output register is free once its word has been taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LRR_ASSERT(a_load_free, cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
   `LRR_ASSERT_NEXT(a_draw_starts, cmd.accept && sts.is_draw, state_ff == ST_RUN && cnt_ff == '0)
   `LRR_ASSERT_NEXT(a_run_ends, state_ff == ST_RUN && last_step, state_ff == ST_DONE)
   `LRR_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)

endmodule

/* rtl/lrr_dp.sv */
// Datapath: seed register, LFSR shift, bit-serial remainder and result register.
module lrr_dp
   import lrr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  lrr_cmd_type        cmd,
   output lrr_sts_type        sts,
   input  logic               req_op,
   input  logic [RANGE_W-1:0] req_range_n,
   input  logic [SEED_W-1:0]  req_seed_in,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_range_error,
   output logic [SEED_W-1:0]  rsp_seed_now
);

   logic [SEED_W-1:0]  seed_ff, seed_in;
   logic [RANGE_W-1:0] range_ff;
   logic [RANGE_W-1:0] rem_ff, rem_in;
   logic               draw_ff;
   logic               err_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               range_error_ff;
   logic [SEED_W-1:0]  seed_now_ff;

   logic               fb;
   logic [SEED_W-1:0]  seed_shift;
   logic [RANGE_W:0]   rem_wide;
   logic [RANGE_W:0]   rem_diff;
   logic [RANGE_W:0]   value_sum;

   assign sts.is_draw = (req_op == OP_DRAW) && (req_range_n != '0);

   // The feedback bits come out first bit first, the same order in which a
   // restoring remainder consumes dividend bits, so no raw value is stored.
   assign fb         = seed_ff[0] ^ seed_ff[1] ^ seed_ff[2] ^ seed_ff[4]
                       ^ seed_ff[6] ^ seed_ff[31];
   assign seed_shift = {fb, seed_ff[SEED_W-1:1]};
   assign rem_wide   = {rem_ff, fb};
   assign rem_diff   = rem_wide - {1'b0, range_ff};
   assign value_sum  = {1'b0, rem_ff} + (RANGE_W+1)'(1);

   always_comb begin
      seed_in = seed_ff;
      rem_in  = rem_ff;
      if (cmd.accept) begin
         rem_in = '0;
         if (req_op == OP_LOAD) begin
            seed_in = req_seed_in;
         end
      end else if (cmd.step) begin
         seed_in = seed_shift;
         if (cmd.last && (seed_shift == '0)) begin
            seed_in = SEED_ESCAPE;
         end
         // The remainder stays below the range, so one compare keeps it reduced.
         if (rem_wide >= {1'b0, range_ff}) begin
            rem_in = rem_diff[RANGE_W-1:0];
         end else begin
            rem_in = rem_wide[RANGE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (cmd.accept) begin
         range_ff <= req_range_n;
         draw_ff  <= sts.is_draw;
         err_ff   <= (req_op == OP_DRAW) && (req_range_n == '0);
      end
      if (cmd.load_rsp) begin
         value_ff       <= draw_ff ? value_sum[VALUE_W-1:0] : '0;
         range_error_ff <= err_ff;
         seed_now_ff    <= seed_ff;
      end
   end

   assign rsp_value       = value_ff;
   assign rsp_range_error = range_error_ff;
   assign rsp_seed_now    = seed_now_ff;

endmodule

/* rtl/lfsr_ranged_random.sv */
// Ranged pseudo-random number source built on a 32-bit Fibonacci LFSR.
//
// A request word carries req_op, req_range_n and req_seed_in. A draw shifts the
// seed ROUNDS times and returns the low 10 bits of (raw mod req_range_n) + 1 on
// rsp_value; a load replaces the seed and returns zero. A draw with a zero range
// returns zero with rsp_range_error set and keeps the seed. Every word returns
// the seed as it stands after the word on rsp_seed_now.
// Both channels use valid/ready handshakes; one response word per request.
// A draw runs ROUNDS LFSR shifts, in each of which the bit-serial remainder
// unit also takes one bit, and then fills the output register; a load or a
// range error goes directly to filling the output register.
// One request is processed at a time: the next request is accepted only once
// the previous result has been moved into the output register.
// The result sits in an output register, so the next request is taken while
// a stalled response waits; a finished result then holds until it is free.
// Reset sets the seed to 0x35683568 and empties the output register.
module lfsr_ranged_random
   import lrr_pkg::*;
#(
   parameter int ROUNDS = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [RANGE_W-1:0] req_range_n,
   input  logic [SEED_W-1:0]  req_seed_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_range_error,
   output logic [SEED_W-1:0]  rsp_seed_now
);

   lrr_cmd_type cmd;
   lrr_sts_type sts;

   lrr_ctrl #(
      .ROUNDS(ROUNDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_op),
      .req_range_n     (req_range_n),
      .req_seed_in     (req_seed_in),
      .rsp_value       (rsp_value),
      .rsp_range_error (rsp_range_error),
      .rsp_seed_now    (rsp_seed_now)
   );

endmodule
